/* rtl/sdet_pkg.sv */
// ----------------------------------------------------------------------------
// sdet_pkg
// types, register map and reset values shared by the switch debounce and
// edge timer block
// ----------------------------------------------------------------------------
package sdet_pkg;

    localparam int PORT_W  = 8;
    localparam int PIN_W   = 3;
    localparam int HOLD_W  = 16;
    localparam int TIME_W  = 32;
    localparam int DATA_W  = 32;
    localparam int ADDR_W  = 4;
    localparam int IDX_W   = 2;

    localparam logic [PIN_W-1:0]  PIN_INDEX_RST    = 3'd0;
    localparam logic              INVERT_LEVEL_RST = 1'b0;
    localparam logic [HOLD_W-1:0] MIN_ON_MS_RST    = 16'd30;
    localparam logic [HOLD_W-1:0] MIN_OFF_MS_RST   = 16'd30;

    typedef enum logic [1:0] {
        PH_RELEASED = 2'd0,
        PH_PEND_ON  = 2'd1,
        PH_PRESSED  = 2'd2,
        PH_PEND_OFF = 2'd3
    } phase_t;

    typedef enum logic [IDX_W-1:0] {
        REG_PIN_INDEX    = 2'd0,
        REG_INVERT_LEVEL = 2'd1,
        REG_MIN_ON_MS    = 2'd2,
        REG_MIN_OFF_MS   = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [PIN_W-1:0]  pin_index;
        logic              invert_level;
        logic [HOLD_W-1:0] min_on_ms;
        logic [HOLD_W-1:0] min_off_ms;
    } cfg_t;

    typedef struct packed {
        logic              debounced_on;
        logic              rising_edge;
        logic              falling_edge;
        logic [TIME_W-1:0] pressed_ms;
        logic [TIME_W-1:0] released_ms;
    } res_t;

endpackage

/* rtl/sdet_regs.sv */
// ----------------------------------------------------------------------------
// sdet_regs
// apb configuration registers: pin select, level sense and hold times
// ----------------------------------------------------------------------------
module sdet_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdet_pkg::ADDR_W-1:0] paddr,
    input  logic [sdet_pkg::DATA_W-1:0] pwdata,
    output logic [sdet_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output sdet_pkg::cfg_t              cfg
);
    import sdet_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_PIN_INDEX:    cfg_next.pin_index    = pwdata[PIN_W-1:0];
                REG_INVERT_LEVEL: cfg_next.invert_level = pwdata[0];
                REG_MIN_ON_MS:    cfg_next.min_on_ms    = pwdata[HOLD_W-1:0];
                REG_MIN_OFF_MS:   cfg_next.min_off_ms   = pwdata[HOLD_W-1:0];
                default:          cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_PIN_INDEX:    prdata = {{(DATA_W-PIN_W){1'b0}}, cfg_reg.pin_index};
            REG_INVERT_LEVEL: prdata = {{(DATA_W-1){1'b0}}, cfg_reg.invert_level};
            REG_MIN_ON_MS:    prdata = {{(DATA_W-HOLD_W){1'b0}}, cfg_reg.min_on_ms};
            REG_MIN_OFF_MS:   prdata = {{(DATA_W-HOLD_W){1'b0}}, cfg_reg.min_off_ms};
            default:          prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.pin_index    <= PIN_INDEX_RST;
            cfg_reg.invert_level <= INVERT_LEVEL_RST;
            cfg_reg.min_on_ms    <= MIN_ON_MS_RST;
            cfg_reg.min_off_ms   <= MIN_OFF_MS_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

/* rtl/sdet_fsm.sv */
// ----------------------------------------------------------------------------
// sdet_fsm
// four-phase debounce machine with press and release timing; the state
// registers double as the result register
// ----------------------------------------------------------------------------
module sdet_fsm (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        advance,
    input  logic                        active,
    input  logic [sdet_pkg::TIME_W-1:0] now_ms,
    input  sdet_pkg::cfg_t              cfg,
    output sdet_pkg::res_t              res
);
    import sdet_pkg::*;

    phase_t              phase_reg,          phase_next;
    logic [TIME_W-1:0]   press_stamp_reg,    press_stamp_next;
    logic [TIME_W-1:0]   release_stamp_reg,  release_stamp_next;
    logic [TIME_W-1:0]   press_length_reg,   press_length_next;
    logic [TIME_W-1:0]   release_length_reg, release_length_next;
    logic                level_reg,          level_next;
    logic                rise_reg,           rise_next;
    logic                fall_reg,           fall_next;
    logic [TIME_W-1:0]   on_elapsed;
    logic [TIME_W-1:0]   off_elapsed;
    logic                on_held;
    logic                off_held;

    assign on_elapsed  = now_ms - press_stamp_reg;
    assign off_elapsed = now_ms - release_stamp_reg;
    assign on_held     = on_elapsed > {{(TIME_W-HOLD_W){1'b0}}, cfg.min_on_ms};
    assign off_held    = off_elapsed > {{(TIME_W-HOLD_W){1'b0}}, cfg.min_off_ms};

    always_comb
    begin
        phase_next          = phase_reg;
        press_stamp_next    = press_stamp_reg;
        release_stamp_next  = release_stamp_reg;
        press_length_next   = press_length_reg;
        release_length_next = release_length_reg;
        level_next          = level_reg;
        rise_next           = rise_reg;
        fall_next           = fall_reg;
        if (advance)
        begin
            unique case (phase_reg)
                PH_RELEASED:
                begin
                    fall_next = 1'b0;
                    if (active)
                    begin
                        phase_next       = PH_PEND_ON;
                        press_stamp_next = now_ms;
                    end
                    else
                    begin
                        release_length_next = off_elapsed;
                    end
                end
                PH_PEND_ON:
                begin
                    if (!active)
                    begin
                        phase_next = PH_RELEASED;
                    end
                    else if (on_held)
                    begin
                        phase_next          = PH_PRESSED;
                        level_next          = 1'b1;
                        rise_next           = 1'b1;
                        release_length_next = press_stamp_reg - release_stamp_reg;
                    end
                end
                PH_PRESSED:
                begin
                    rise_next = 1'b0;
                    if (!active)
                    begin
                        phase_next         = PH_PEND_OFF;
                        release_stamp_next = now_ms;
                    end
                    else
                    begin
                        press_length_next = on_elapsed;
                    end
                end
                PH_PEND_OFF:
                begin
                    if (active)
                    begin
                        phase_next = PH_PRESSED;
                    end
                    else if (off_held)
                    begin
                        phase_next        = PH_RELEASED;
                        level_next        = 1'b0;
                        fall_next         = 1'b1;
                        press_length_next = release_stamp_reg - press_stamp_reg;
                    end
                end
                default:
                begin
                    phase_next = PH_RELEASED;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg          <= PH_RELEASED;
            press_stamp_reg    <= '0;
            release_stamp_reg  <= '0;
            press_length_reg   <= '0;
            release_length_reg <= '0;
            level_reg          <= 1'b0;
            rise_reg           <= 1'b0;
            fall_reg           <= 1'b0;
        end
        else
        begin
            phase_reg          <= phase_next;
            press_stamp_reg    <= press_stamp_next;
            release_stamp_reg  <= release_stamp_next;
            press_length_reg   <= press_length_next;
            release_length_reg <= release_length_next;
            level_reg          <= level_next;
            rise_reg           <= rise_next;
            fall_reg           <= fall_next;
        end
    end

    assign res.debounced_on = level_reg;
    assign res.rising_edge  = rise_reg;
    assign res.falling_edge = fall_reg;
    assign res.pressed_ms   = press_length_reg;
    assign res.released_ms  = release_length_reg;

    a_rise_pressed: assert property (@(posedge clk) disable iff (!rst_n)
        rise_reg |-> level_reg)
        else $error("rising edge flag without debounced level");

    a_fall_released: assert property (@(posedge clk) disable iff (!rst_n)
        fall_reg |-> !level_reg)
        else $error("falling edge flag with debounced level");

    a_level_phase: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg == (phase_reg == PH_PRESSED || phase_reg == PH_PEND_OFF))
        else $error("debounced level disagrees with phase");

    a_state_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(phase_reg) && $stable(press_length_reg)
                     && $stable(release_length_reg) && $stable(rise_reg))
        else $error("state changed without an item");

    a_rise_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rise_reg) |-> $past(phase_reg) == PH_PEND_ON)
        else $error("press confirmed outside pending on");

endmodule

/* rtl/switch_debounce_edge_timer_core.sv */
// ----------------------------------------------------------------------------
// switch_debounce_edge_timer_core
// debounces one pin of a polled port and times presses and releases
//
// each input item is one poll (port_value, now_ms) on a valid/ready channel;
// each poll yields exactly one result item (debounced_on, rising_edge,
// falling_edge, pressed_ms, released_ms) on a valid/ready output channel.
// an accepted item lands in the input register; when it advances, the phase
// machine updates from it and the updated state registers are the result.
// one item per cycle is sustained while out_ready is high: the phase step is
// a combinational 32-bit subtract and compare, and the input register takes
// a new item as its held item advances.
// when out_ready is low the result holds, the input register fills, and
// in_ready drops until the result is taken.
// reset clears the phase to released, all stamps and lengths to zero and
// the registers to pin 0, active low, 30 ms on and off hold.
// configuration goes through the apb port, at byte address 4 * index; the user
// must write it only while no item is in flight, the block does not enforce this.
// ----------------------------------------------------------------------------
module switch_debounce_edge_timer_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [sdet_pkg::ADDR_W-1:0] paddr,
    input  logic [sdet_pkg::DATA_W-1:0] pwdata,
    output logic [sdet_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sdet_pkg::PORT_W-1:0] port_value,
    input  logic [sdet_pkg::TIME_W-1:0] now_ms,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic                        debounced_on,
    output logic                        rising_edge,
    output logic                        falling_edge,
    output logic [sdet_pkg::TIME_W-1:0] pressed_ms,
    output logic [sdet_pkg::TIME_W-1:0] released_ms
);
    import sdet_pkg::*;

    cfg_t              cfg;
    res_t              res;
    logic              s1_valid_reg, s1_valid_next;
    logic [PORT_W-1:0] port_reg;
    logic [TIME_W-1:0] now_reg;
    logic              out_valid_reg, out_valid_next;
    logic              advance;
    logic              active;

    sdet_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    assign advance  = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || advance;
    assign active   = !port_reg[cfg.pin_index] ^ cfg.invert_level;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
        begin
            s1_valid_next = in_valid;
        end
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            port_reg <= port_value;
            now_reg  <= now_ms;
        end
    end

    sdet_fsm u_fsm (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (advance),
        .active  (active),
        .now_ms  (now_reg),
        .cfg     (cfg),
        .res     (res)
    );

    assign out_valid    = out_valid_reg;
    assign debounced_on = res.debounced_on;
    assign rising_edge  = res.rising_edge;
    assign falling_edge = res.falling_edge;
    assign pressed_ms   = res.pressed_ms;
    assign released_ms  = res.released_ms;

endmodule
